>>> hdl/dwvd_pkg.sv
// Package for the deque with value delete: field widths, operation codes,
// status codes, command and result types shared by the front, queue and back.
// No dependencies.
package dwvd_pkg;

  localparam int unsigned ValueW       = 32;
  localparam int unsigned CountW       = 6;
  localparam int unsigned OpW          = 4;
  localparam int unsigned StatusW      = 3;
  localparam int unsigned DefaultDepth = 32;

  // Operation codes as carried on the input stream
  localparam logic [OpW-1:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [OpW-1:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [OpW-1:0] OP_POP_FRONT  = 4'd2;
  localparam logic [OpW-1:0] OP_POP_BACK   = 4'd3;
  localparam logic [OpW-1:0] OP_READ_ALL   = 4'd4;
  localparam logic [OpW-1:0] OP_READ_FIRST = 4'd5;
  localparam logic [OpW-1:0] OP_READ_LAST  = 4'd6;
  localparam logic [OpW-1:0] OP_DELETE     = 4'd7;
  localparam logic [OpW-1:0] OP_CLEAR      = 4'd8;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_CLAMPED   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_POP_BACK,
    CMD_READ_ALL,
    CMD_READ_FIRST,
    CMD_READ_LAST,
    CMD_DELETE,
    CMD_CLEAR,
    CMD_NOP
  } cmd_e;

  typedef struct packed {
    cmd_e                     kind;
    logic signed [ValueW-1:0] value;
    logic [CountW-1:0]        count;
  } cmd_t;

  typedef struct packed {
    logic signed [ValueW-1:0] element;
    logic                     has_element;
    status_e                  status;
    logic                     last;
  } result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_DEL_CMP,
    BK_DEL_MOVE,
    BK_RESP
  } back_state_e;

endpackage

>>> hdl/dwvd_front.sv
// Front stage: takes input transfers, decodes the operation code into a
// command and holds it in a register until the command queue takes it.
// Depends on dwvd_pkg.
module dwvd_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [dwvd_pkg::OpW-1:0]       in_op_i,
  input  logic signed [dwvd_pkg::ValueW-1:0] in_value_i,
  input  logic [dwvd_pkg::CountW-1:0]    in_count_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output dwvd_pkg::cmd_t                 cmd_o
);
  import dwvd_pkg::*;

  logic valid_q, valid_d;
  cmd_t cmd_q;
  cmd_e kind;

  always_comb begin
    case (in_op_i)
      OP_PUSH_FRONT: kind = CMD_PUSH_FRONT;
      OP_PUSH_BACK:  kind = CMD_PUSH_BACK;
      OP_POP_FRONT:  kind = CMD_POP_FRONT;
      OP_POP_BACK:   kind = CMD_POP_BACK;
      OP_READ_ALL:   kind = CMD_READ_ALL;
      OP_READ_FIRST: kind = CMD_READ_FIRST;
      OP_READ_LAST:  kind = CMD_READ_LAST;
      OP_DELETE:     kind = CMD_DELETE;
      OP_CLEAR:      kind = CMD_CLEAR;
      default:       kind = CMD_NOP;
    endcase
  end

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q.kind  <= kind;
      cmd_q.value <= in_value_i;
      cmd_q.count <= in_count_i;
    end
  end

endmodule

>>> hdl/dwvd_cmd_fifo.sv
// Two-entry command queue between the front stage and the back end.
// Depends on dwvd_pkg.
module dwvd_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  dwvd_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output dwvd_pkg::cmd_t pop_cmd_o
);
  import dwvd_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> hdl/dwvd_back.sv
// Back end: holds the circular element store, front index and occupancy,
// carries out one command at a time and drives the registered result port.
// Depends on dwvd_pkg.
module dwvd_back #(
  parameter int unsigned DEPTH = dwvd_pkg::DefaultDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  dwvd_pkg::cmd_t    cmd_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output dwvd_pkg::result_t res_o
);
  import dwvd_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned OccW = $clog2(DEPTH + 1);
  localparam int unsigned CntW = (OccW > CountW) ? OccW : CountW;

  function automatic logic [IdxW-1:0] slot_of(input logic [IdxW-1:0] base,
                                              input logic [OccW-1:0] pos);
    logic [OccW:0] sum;
    sum = (OccW + 1)'(base) + (OccW + 1)'(pos);
    if (sum >= (OccW + 1)'(DEPTH)) begin
      sum = sum - (OccW + 1)'(DEPTH);
    end
    return sum[IdxW-1:0];
  endfunction

  back_state_e state_q, state_d;
  logic [IdxW-1:0]   front_q, front_d;
  logic [OccW-1:0]   occ_q, occ_d;
  logic [OccW-1:0]   pos_q, pos_d;
  logic [OccW-1:0]   rem_q, rem_d;
  status_e           status_q, status_d;
  logic [ValueW-1:0] value_q, value_d;

  logic [ValueW-1:0] mem_q [DEPTH];
  logic [ValueW-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr, mem_raddr;
  logic [ValueW-1:0] mem_wdata;

  logic    out_valid_q;
  result_t out_q;
  logic    emit, emit_ok;
  result_t emit_res;

  logic            full, empty, clamp, match;
  logic [IdxW-1:0] front_dec;
  logic [OccW-1:0] n_sel, read_n, rd_start, pos_inc, pos_inc2;
  status_e         rd_status;

  assign full      = (occ_q == OccW'(DEPTH));
  assign empty     = (occ_q == '0);
  assign front_dec = (front_q == '0) ? IdxW'(DEPTH - 1) : front_q - IdxW'(1);
  assign clamp     = CntW'(cmd_i.count) > CntW'(occ_q);
  assign n_sel     = clamp ? occ_q : OccW'(CntW'(cmd_i.count));
  assign read_n    = (cmd_i.kind == CMD_READ_ALL) ? occ_q : n_sel;
  assign rd_start  = (cmd_i.kind == CMD_READ_LAST) ? occ_q - n_sel : '0;
  assign rd_status = ((cmd_i.kind != CMD_READ_ALL) && clamp) ? ST_CLAMPED : ST_OK;
  assign pos_inc   = pos_q + OccW'(1);
  assign pos_inc2  = pos_q + OccW'(2);
  assign match     = (rdata_q == value_q);
  assign emit_ok   = !out_valid_q || res_ready_i;

  // Outputs: store access, command pop and result emission
  always_comb begin
    cmd_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = front_q;
    mem_wdata   = cmd_i.value;
    mem_re      = 1'b0;
    mem_raddr   = front_q;
    emit        = 1'b0;
    emit_res    = '{element: '0, has_element: 1'b0, status: status_q, last: 1'b1};
    case (state_q)
      BK_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            CMD_PUSH_FRONT: begin
              mem_we    = !full;
              mem_waddr = front_dec;
            end
            CMD_PUSH_BACK: begin
              mem_we    = !full;
              mem_waddr = slot_of(front_q, occ_q);
            end
            CMD_READ_ALL, CMD_READ_FIRST, CMD_READ_LAST: begin
              mem_re    = !empty && (read_n != '0);
              mem_raddr = slot_of(front_q, rd_start);
            end
            CMD_DELETE: begin
              mem_re = !empty;
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        if (emit_ok) begin
          emit     = 1'b1;
          emit_res = '{element: rdata_q, has_element: 1'b1, status: status_q,
                       last: (rem_q == OccW'(1))};
          mem_re    = (rem_q != OccW'(1));
          mem_raddr = slot_of(front_q, pos_inc);
        end
      end
      BK_DEL_CMP: begin
        // the next element is needed both to keep searching and to close the gap
        mem_re    = (pos_inc < occ_q);
        mem_raddr = slot_of(front_q, pos_inc);
      end
      BK_DEL_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(front_q, pos_q);
        mem_wdata = rdata_q;
        mem_re    = (pos_inc2 < occ_q);
        mem_raddr = slot_of(front_q, pos_inc2);
      end
      BK_RESP: begin
        emit = emit_ok;
      end
      default: ;
    endcase
  end

  // Next state and datapath registers
  always_comb begin
    state_d  = state_q;
    front_d  = front_q;
    occ_d    = occ_q;
    pos_d    = pos_q;
    rem_d    = rem_q;
    status_d = status_q;
    value_d  = value_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          state_d  = BK_RESP;
          status_d = ST_OK;
          case (cmd_i.kind)
            CMD_PUSH_FRONT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                front_d = front_dec;
                occ_d   = occ_q + OccW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                occ_d = occ_q + OccW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                front_d = slot_of(front_q, OccW'(1));
                occ_d   = occ_q - OccW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                occ_d = occ_q - OccW'(1);
              end
            end
            CMD_READ_ALL, CMD_READ_FIRST, CMD_READ_LAST: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                status_d = rd_status;
                if (read_n != '0) begin
                  state_d = BK_READ;
                  pos_d   = rd_start;
                  rem_d   = read_n;
                end
              end
            end
            CMD_DELETE: begin
              if (empty) begin
                status_d = ST_EMPTY;
              end else begin
                state_d = BK_DEL_CMP;
                pos_d   = '0;
                value_d = cmd_i.value;
              end
            end
            CMD_CLEAR: begin
              occ_d   = '0;
              front_d = '0;
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        if (emit_ok) begin
          if (rem_q == OccW'(1)) begin
            state_d = BK_IDLE;
          end else begin
            rem_d = rem_q - OccW'(1);
            pos_d = pos_inc;
          end
        end
      end
      BK_DEL_CMP: begin
        if (match) begin
          if (pos_inc < occ_q) begin
            state_d = BK_DEL_MOVE;
          end else begin
            occ_d    = occ_q - OccW'(1);
            status_d = ST_OK;
            state_d  = BK_RESP;
          end
        end else if (pos_inc < occ_q) begin
          pos_d = pos_inc;
        end else begin
          status_d = ST_NOT_FOUND;
          state_d  = BK_RESP;
        end
      end
      BK_DEL_MOVE: begin
        if (pos_inc2 < occ_q) begin
          pos_d = pos_inc;
        end else begin
          occ_d    = occ_q - OccW'(1);
          status_d = ST_OK;
          state_d  = BK_RESP;
        end
      end
      BK_RESP: begin
        if (emit_ok) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      front_q     <= '0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      occ_q   <= occ_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    rem_q    <= rem_d;
    status_q <= status_d;
    value_q  <= value_d;
    if (emit) begin
      out_q <= emit_res;
    end
  end

  // Element store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

>>> hdl/deque_with_value_delete.sv
// Bounded double-ended queue of signed 32-bit values with delete-by-value and
// run readouts. Commands pass a decode register and a two-entry queue before
// a back end that owns a circular store (one write and one registered read
// per cycle); the result leaves through an output register. Push, pop,
// clear and unused codes each give one status result. A readout gives one
// result per element, or a single one with no element. A delete walks the
// store from the front and closes the gap behind a match.
module deque_with_value_delete #(
  parameter int unsigned DEPTH = dwvd_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // value[31:0], count[37:32], zero pad
  input  logic [3:0]  s_axis_tuser,  // operation[3:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // element[31:0]
  output logic [3:0]  m_axis_tuser,  // has_element[0], status[3:1]
  output logic        m_axis_tlast   // last
);
  import dwvd_pkg::*;

  logic    f_valid, f_ready, q_valid, q_ready;
  cmd_t    f_cmd, q_cmd;
  result_t res;

  dwvd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_value_i  (s_axis_tdata[31:0]),
    .in_count_i  (s_axis_tdata[37:32]),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  dwvd_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (q_cmd)
  );

  dwvd_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = res.element;
  assign m_axis_tuser = {res.status, res.has_element};
  assign m_axis_tlast = res.last;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for deque_with_value_delete: streams deque commands in,
// checks every result transfer against a tracked copy of the deque contents.
// Depends on dwvd_pkg and the deque_with_value_delete RTL.
module tb_top;
  import dwvd_pkg::*;

  localparam int unsigned Depth      = DefaultDepth;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned MaxReports = 10;

  // Tracks the deque contents and the results still owed by the block
  class deque_tracker;
    logic signed [ValueW-1:0] slots [Depth];
    int unsigned head;
    int unsigned fill;
    result_t     owed_q [$];
    int unsigned mismatches;
    int unsigned cmds_seen;
    int unsigned results_checked;
    int unsigned status_hits [5];

    function new();
      head = 0;
      fill = 0;
      mismatches = 0;
      cmds_seen = 0;
      results_checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void owe(logic signed [ValueW-1:0] elem, logic has, status_e st, logic fin);
      result_t r;
      r.element     = elem;
      r.has_element = has;
      r.status      = st;
      r.last        = fin;
      owed_q.push_back(r);
      status_hits[st]++;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Random value currently held, for delete targets
    function logic signed [ValueW-1:0] any_stored();
      return slots[(head + $urandom_range(0, fill - 1)) % Depth];
    endfunction

    function void apply_command(logic [OpW-1:0] op, logic signed [ValueW-1:0] v,
                                logic [CountW-1:0] k);
      status_e     st;
      int unsigned n;
      int unsigned start;
      int unsigned pos;
      st = ST_OK;
      cmds_seen++;
      case (op)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (fill >= Depth) begin
            st = ST_FULL;
          end else if (op == OP_PUSH_FRONT) begin
            head = (head + Depth - 1) % Depth;
            slots[head] = v;
            fill++;
          end else begin
            slots[(head + fill) % Depth] = v;
            fill++;
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (fill == 0) begin
            st = ST_EMPTY;
          end else begin
            if (op == OP_POP_FRONT) head = (head + 1) % Depth;
            fill--;
          end
        end
        OP_READ_ALL, OP_READ_FIRST, OP_READ_LAST: begin
          if (fill == 0) begin
            owe('0, 1'b0, ST_EMPTY, 1'b1);
            return;
          end
          if (op == OP_READ_ALL) begin
            n = fill;
            start = 0;
          end else begin
            n = k;
            if (n > fill) begin
              n = fill;
              st = ST_CLAMPED;
            end
            start = (op == OP_READ_FIRST) ? 0 : fill - n;
          end
          if (n == 0) begin
            owe('0, 1'b0, st, 1'b1);
          end else begin
            for (int unsigned i = 0; i < n; i++)
              owe(slots[(head + start + i) % Depth], 1'b1, st, (i + 1 == n));
          end
          return;
        end
        OP_DELETE: begin
          if (fill == 0) begin
            st = ST_EMPTY;
          end else begin
            pos = 0;
            while (pos < fill && slots[(head + pos) % Depth] !== v) pos++;
            if (pos == fill) begin
              st = ST_NOT_FOUND;
            end else begin
              // later entries slide one place toward the front
              for (int unsigned j = pos; j + 1 < fill; j++)
                slots[(head + j) % Depth] = slots[(head + j + 1) % Depth];
              fill--;
            end
          end
        end
        OP_CLEAR: begin
          fill = 0;
          head = 0;
        end
        default: ;
      endcase
      owe('0, 1'b0, st, 1'b1);
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_checked++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected result elem=%0d has=%0b status=%0d last=%0b",
                   $realtime, got.element, got.has_element, got.status, got.last);
        return;
      end
      want = owed_q.pop_front();
      if (got.element !== want.element || got.has_element !== want.has_element ||
          got.status !== want.status || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("%0t: mismatch: expected elem=%0d has=%0b status=%0d last=%0b,",
                   $realtime, want.element, want.has_element, want.status, want.last);
          $display("    got elem=%0d has=%0b status=%0d last=%0b",
                   got.element, got.has_element, got.status, got.last);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // value[31:0], count[37:32], zero pad
  logic [3:0]  s_axis_tuser = '0;  // operation[3:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // element[31:0]
  logic [3:0]  m_axis_tuser;       // has_element[0], status[3:1]
  logic        m_axis_tlast;

  deque_tracker tracker;
  result_t      observed;
  bit           tx_calm = 1'b0;
  bit           rx_calm = 1'b0;
  int unsigned  rx_hold_len = 0;
  int unsigned  rx_hold_cnt = 0;
  int unsigned  rx_stall_cnt = 0;
  int unsigned  cycle_cnt = 0;

  deque_with_value_delete #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still owed", cycle_cnt,
               tracker.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return $signed($urandom_range(0, 7)) - 4;  // small pool gives duplicates
    if (r < 45) return 32'sh7fff_ffff;
    if (r < 50) return 32'sh8000_0000;
    return $urandom;
  endfunction

  function automatic logic signed [ValueW-1:0] pick_target();
    if (tracker.fill != 0 && $urandom_range(0, 99) < 70) return tracker.any_stored();
    return pick_value();
  endfunction

  function automatic logic [CountW-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 60) return CountW'($urandom_range(1, tracker.fill + 1));
    if (r < 75) return CountW'(tracker.fill);
    return CountW'($urandom_range(0, 63));
  endfunction

  // Receiver: random stalls, plus long hold-offs requested through rx_hold_len
  always @(negedge clk_i) begin
    if (rx_hold_len != 0) begin
      rx_hold_cnt = rx_hold_len;
      rx_hold_len = 0;
    end
    if (rx_hold_cnt != 0) begin
      rx_hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_cnt != 0) begin
      rx_stall_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      rx_stall_cnt = rx_calm ? 0 : pick_gap();
      m_axis_tready <= (rx_stall_cnt == 0);
      if (rx_stall_cnt != 0) rx_stall_cnt--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      observed.element     = m_axis_tdata;
      observed.has_element = m_axis_tuser[0];
      observed.status      = status_e'(m_axis_tuser[3:1]);
      observed.last        = m_axis_tlast;
      tracker.check_result(observed);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_cmd(input logic [OpW-1:0] op, input logic signed [ValueW-1:0] v,
                          input logic [CountW-1:0] k);
    int unsigned gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, k, v};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.apply_command(op, v, k);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
  endtask

  task automatic run_directed();
    // everything on an empty deque
    send_cmd(OP_POP_FRONT, 0, 0);
    send_cmd(OP_POP_BACK, 0, 0);
    send_cmd(OP_READ_ALL, 0, 0);
    send_cmd(OP_READ_FIRST, 0, 6'd5);
    send_cmd(OP_READ_LAST, 0, 6'd0);
    send_cmd(OP_DELETE, 32'sd17, 0);
    // extremes of the value field
    send_cmd(OP_PUSH_BACK, 32'sh7fff_ffff, 0);
    send_cmd(OP_PUSH_FRONT, 32'sh8000_0000, 0);
    send_cmd(OP_PUSH_BACK, 0, 0);
    send_cmd(OP_PUSH_BACK, -1, 0);
    send_cmd(OP_READ_ALL, 0, 0);
    send_cmd(OP_READ_FIRST, 0, 6'd0);
    send_cmd(OP_READ_LAST, -1, 6'd63);
    send_cmd(OP_READ_FIRST, 0, 6'd2);
    send_cmd(OP_DELETE, 32'sd12345, 0);        // no match
    send_cmd(OP_DELETE, 32'sh8000_0000, 0);    // match at the front
    send_cmd(OP_DELETE, -1, 0);                // match at the back
    send_cmd(OP_PUSH_BACK, 32'sd5, 0);
    send_cmd(OP_DELETE, 0, 0);                 // match in the middle
    send_cmd(OP_READ_LAST, 0, 6'd1);
    send_cmd(OP_POP_FRONT, 0, 0);
    send_cmd(OP_POP_BACK, 0, 0);               // last element leaves
    send_cmd(4'd9, 0, 0);
    send_cmd(OP_PUSH_FRONT, 32'sd9, 0);
    send_cmd(4'd15, -1, 6'd63);
    send_cmd(OP_CLEAR, 0, 0);
  endtask

  task automatic run_mix(input int unsigned items, input int unsigned push_pct);
    int unsigned             r;
    logic [OpW-1:0]          op;
    logic signed [ValueW-1:0] v;
    logic [CountW-1:0]       k;
    repeat (items) begin
      v = pick_value();
      k = CountW'($urandom_range(0, 63));
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 22) begin
          op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        end else if (r < 50) begin
          r = $urandom_range(0, 2);
          op = (r == 0) ? OP_READ_ALL : (r == 1) ? OP_READ_FIRST : OP_READ_LAST;
          k = pick_count();
        end else if (r < 82) begin
          op = OP_DELETE;
          v = pick_target();
        end else if (r < 86) begin
          op = OP_CLEAR;
        end else if (r < 93) begin
          op = OpW'($urandom_range(9, 15));
        end else begin
          op = OP_PUSH_BACK;
        end
      end
      send_cmd(op, v, k);
    end
  endtask

  initial begin
    tracker = new();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();

    // fill past capacity, then read long runs under a held-off receiver
    tx_calm = ($urandom_range(0, 1) == 1);
    run_mix(36, 100);
    rx_hold_len = 400;
    send_cmd(OP_READ_ALL, 0, 0);
    send_cmd(OP_READ_LAST, 0, 6'd63);
    send_cmd(OP_READ_FIRST, 0, 6'd31);
    send_cmd(OP_READ_ALL, 0, 0);
    send_cmd(OP_READ_FIRST, 0, 6'd1);  // waits on a stalled input
    wait_drained();

    for (int s = 0; s < 6; s++) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      run_mix(19, (s == 5) ? 15 : $urandom_range(30, 65));
      if (s == 2) begin
        wait_drained();
        rx_hold_len = 150;
        send_cmd(OP_READ_ALL, 0, 0);
        send_cmd(OP_READ_LAST, 0, pick_count());
      end
    end

    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("Run covered %0d commands and %0d result transfers (%0d mismatches)",
             tracker.cmds_seen, tracker.results_checked, tracker.mismatches);
    $display("Statuses owed: ok %0d, full %0d, empty %0d, not found %0d, clamped %0d",
             tracker.status_hits[ST_OK], tracker.status_hits[ST_FULL],
             tracker.status_hits[ST_EMPTY], tracker.status_hits[ST_NOT_FOUND],
             tracker.status_hits[ST_CLAMPED]);
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
